### hw/rtl/rgb_3x3_convolution_filter_macros.svh
// Assertion macros for the checker file of the 3x3 RGB convolution filter.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef RGB_3X3_CONVOLUTION_FILTER_MACROS_SVH
`define RGB_3X3_CONVOLUTION_FILTER_MACROS_SVH

// Same-cycle implication.
`define RGBCF_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RGBCF_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/rgbcf_pkg.sv
// Shared constants, types and arithmetic helpers of the 3x3 RGB convolution filter.
// No dependencies; the filter top level, rgbcf_linebuf and rgbcf_kernel import it.
package rgbcf_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 4096;
   localparam int COEF_FRAC_BITS = 12;
   localparam int COEF_BITS      = 18;

   localparam int CHAN_W       = 8;
   localparam int NUM_CHAN     = 3;
   localparam int PIX_W        = NUM_CHAN * CHAN_W;
   localparam int COEF_ROW_W   = 3 * COEF_BITS;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_IDX_W    = 3;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int FILL_W    = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W     = $clog2(MAX_HEIGHT + 3);
   localparam int ROW_CMP_W = ROW_W + 1;

   // unsigned pixel (one sign bit added) times signed weight, then sums of three and nine
   localparam int PROD_W   = CHAN_W + 1 + COEF_BITS;
   localparam int ROWSUM_W = PROD_W + 2;
   localparam int SUM_W    = PROD_W + 4;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET       = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET      = HEIGHT_REG_W'(480);
   localparam logic [COEF_ROW_W-1:0]   COEF_EDGE_RESET   = '0;
   localparam logic [COEF_ROW_W-1:0]   COEF_MIDDLE_RESET =
      COEF_ROW_W'(1) << (COEF_BITS + COEF_FRAC_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_COEF_TOP     = 3'd2,
      CSR_COEF_MIDDLE  = 3'd3,
      CSR_COEF_BOTTOM  = 3'd4
   } csr_index_type;

   typedef logic [PIX_W-1:0] pix_type;

   // [row][column]: row 0 is the oldest line, column 0 the leftmost pixel
   typedef logic [2:0][2:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic valid;
      logic emit;
      logic interior;
      logic last;
   } ctl_type;

   function automatic logic signed [COEF_BITS-1:0] coef_at(
      input logic [COEF_ROW_W-1:0] coef_row,
      input int unsigned           col
   );
      return coef_row[col*COEF_BITS +: COEF_BITS];
   endfunction

   // Round to nearest with halves up, then clamp to the channel range.
   function automatic logic [CHAN_W-1:0] round_clamp(input logic signed [SUM_W-1:0] sum);
      logic [SUM_W-1:0] biased;
      logic [SUM_W-1:0] quot;
      biased = $unsigned(sum) + (SUM_W'(1) << (COEF_FRAC_BITS - 1));
      quot   = biased >> COEF_FRAC_BITS;
      if (sum[SUM_W-1]) begin
         return '0;
      end else if (quot > SUM_W'({CHAN_W{1'b1}})) begin
         return {CHAN_W{1'b1}};
      end else begin
         return quot[CHAN_W-1:0];
      end
   endfunction

endpackage

### hw/rtl/rgbcf_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Read during write to the same address returns the old contents. No dependencies.
module rgbcf_ram #(
   parameter int  WIDTH = 24,
   parameter int  DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### hw/rtl/rgbcf_linebuf.sv
// Front end of the filter: frame position tracking, the two line stores with
// forwarding, and the 3x3 window. Uses rgbcf_pkg and rgbcf_ram.
module rgbcf_linebuf
   import rgbcf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    req_valid,
   input  logic [CHAN_W-1:0]       pix_red,
   input  logic [CHAN_W-1:0]       pix_green,
   input  logic [CHAN_W-1:0]       pix_blue,
   input  logic                    flush,
   input  logic [WIDTH_REG_W-1:0]  image_width,
   input  logic [HEIGHT_REG_W-1:0] image_height,
   output ctl_type                 s2_ctl,
   output window_type              window,
   output pix_type                 s2_ctr_pix
);

   // position in the frame
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   // entries below this address have been written since reset
   logic [FILL_W-1:0] fill_ff, fill_in;

   // stage 1: line store read data arrives
   ctl_type           s1_ctl_ff, s1_ctl_in;
   logic [COL_W-1:0]  s1_c_ff, s1_c_in;
   logic [COL_W-1:0]  s1_wm1_ff, s1_wm1_in;
   logic [COL_W-1:0]  s1_cm1_ff, s1_cm1_in;
   logic              s1_c0_ff, s1_c0_in;
   logic [2:0]        s1_unw_ff, s1_unw_in;
   pix_type           s1_fresh_ff, s1_fresh_in;

   // write that landed at the same edge as the stage 1 read
   logic              byp_valid_ff, byp_valid_in;
   logic [COL_W-1:0]  byp_addr_ff, byp_addr_in;
   pix_type           byp_up_ff, byp_up_in;
   pix_type           byp_lo_ff, byp_lo_in;

   // stage 2: window
   ctl_type           s2_ctl_ff, s2_ctl_in;
   pix_type           s2_ctr_ff, s2_ctr_in;
   window_type        win_ff, win_in;

   logic                    accept;
   logic [WIDTH_REG_W-1:0]  w_cl;
   logic [HEIGHT_REG_W-1:0] h_cl;
   logic                    col_wrap;
   logic [COL_W-1:0]        c0;
   logic [ROW_W-1:0]        r0;
   logic [ROW_CMP_W-1:0]    r_ext;
   logic [ROW_CMP_W-1:0]    h_ext;
   logic                    tail0;
   logic                    emit0;
   logic                    last0;
   logic                    interior0;
   pix_type                 fresh0;
   logic [COL_W-1:0]        wm1_0;
   logic [COL_W-1:0]        cm1_0;
   logic [WIDTH_REG_W-1:0]  c_next;

   logic                    s1_write;
   pix_type                 up_rd_a, up_rd_b, lo_rd_a, lo_rd_b;
   pix_type                 up1, lo1, ctr1;

   assign accept   = req_valid && adv;
   assign s1_write = s1_ctl_ff.valid && adv;

   // ---------------- stage 0: position and read issue ----------------
   always_comb begin
      w_cl = image_width;
      if (image_width == '0) begin
         w_cl = WIDTH_REG_W'(1);
      end else if (image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
         w_cl = WIDTH_REG_W'(MAX_WIDTH);
      end
      h_cl = image_height;
      if (image_height == '0) begin
         h_cl = HEIGHT_REG_W'(1);
      end else if (image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
         h_cl = HEIGHT_REG_W'(MAX_HEIGHT);
      end

      // a narrower width written since the last item wraps the column
      col_wrap = WIDTH_REG_W'(col_ff) >= w_cl;
      c0       = col_wrap ? '0 : col_ff;
      r0       = col_wrap ? row_ff + ROW_W'(1) : row_ff;
      r_ext    = ROW_CMP_W'(r0);
      h_ext    = ROW_CMP_W'(h_cl);

      tail0     = r_ext >= h_ext;
      emit0     = (r0 >= ROW_W'(2)) || ((r0 == ROW_W'(1)) && (c0 != '0));
      last0     = emit0 && (r_ext > h_ext);
      interior0 = (c0 >= COL_W'(2)) && (r0 >= ROW_W'(2)) && (r_ext < h_ext);
      fresh0    = (tail0 || flush) ? '0 : {pix_blue, pix_green, pix_red};

      wm1_0  = COL_W'(w_cl - WIDTH_REG_W'(1));
      cm1_0  = c0 - COL_W'(1);
      c_next = WIDTH_REG_W'(c0) + WIDTH_REG_W'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last0) begin
            col_in = '0;
            row_in = '0;
         end else if (c_next >= w_cl) begin
            col_in = '0;
            row_in = r0 + ROW_W'(1);
         end else begin
            col_in = COL_W'(c_next);
            row_in = r0;
         end
      end

      s1_ctl_in = '0;
      if (accept) begin
         s1_ctl_in.valid    = 1'b1;
         s1_ctl_in.emit     = emit0;
         s1_ctl_in.interior = interior0;
         s1_ctl_in.last     = last0;
      end
      s1_c_in     = c0;
      s1_wm1_in   = wm1_0;
      s1_cm1_in   = cm1_0;
      s1_c0_in    = (c0 == '0);
      s1_unw_in   = {FILL_W'(cm1_0) >= fill_ff, FILL_W'(wm1_0) >= fill_ff,
                     FILL_W'(c0) >= fill_ff};
      s1_fresh_in = fresh0;
   end

   // ---------------- stage 1: forwarding, write back, window shift ----------------
   always_comb begin
      if (byp_valid_ff && (byp_addr_ff == s1_c_ff)) begin
         up1 = byp_up_ff;
         lo1 = byp_lo_ff;
      end else if (s1_unw_ff[0]) begin
         up1 = '0;
         lo1 = '0;
      end else begin
         up1 = up_rd_a;
         lo1 = lo_rd_a;
      end

      // first column: end of the upper line; otherwise the pixel just left of it
      if (s1_c0_ff) begin
         if (byp_valid_ff && (byp_addr_ff == s1_wm1_ff)) begin
            ctr1 = byp_up_ff;
         end else if (s1_unw_ff[1]) begin
            ctr1 = '0;
         end else begin
            ctr1 = up_rd_b;
         end
      end else begin
         if (byp_valid_ff && (byp_addr_ff == s1_cm1_ff)) begin
            ctr1 = byp_lo_ff;
         end else if (s1_unw_ff[2]) begin
            ctr1 = '0;
         end else begin
            ctr1 = lo_rd_b;
         end
      end

      byp_valid_in = accept && s1_ctl_ff.valid;
      byp_addr_in  = s1_c_ff;
      byp_up_in    = lo1;
      byp_lo_in    = s1_fresh_ff;

      fill_in = fill_ff;
      if (s1_write && (FILL_W'(s1_c_ff) == fill_ff)) begin
         fill_in = fill_ff + FILL_W'(1);
      end

      s2_ctl_in = s1_ctl_ff;
      s2_ctr_in = ctr1;
      win_in    = win_ff;
      if (s1_ctl_ff.valid) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = up1;
         win_in[1][2] = lo1;
         win_in[2][2] = s1_fresh_ff;
      end
   end

   rgbcf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper_ram (
      .clock     (clock),
      .wr_en     (s1_write),
      .wr_addr   (s1_c_ff),
      .wr_data   (lo1),
      .rd_en     (accept),
      .rd_addr_a (c0),
      .rd_addr_b (wm1_0),
      .rd_data_a (up_rd_a),
      .rd_data_b (up_rd_b)
   );

   rgbcf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_lower_ram (
      .clock     (clock),
      .wr_en     (s1_write),
      .wr_addr   (s1_c_ff),
      .wr_data   (s1_fresh_ff),
      .rd_en     (accept),
      .rd_addr_a (c0),
      .rd_addr_b (cm1_0),
      .rd_data_a (lo_rd_a),
      .rd_data_b (lo_rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         fill_ff      <= '0;
         s1_ctl_ff    <= '0;
         s2_ctl_ff    <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         fill_ff <= fill_in;
         if (adv) begin
            s1_ctl_ff    <= s1_ctl_in;
            s2_ctl_ff    <= s2_ctl_in;
            byp_valid_ff <= byp_valid_in;
         end
      end
   end

   // payload: hold while the pipeline is frozen
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_c_ff     <= s1_c_in;
         s1_wm1_ff   <= s1_wm1_in;
         s1_cm1_ff   <= s1_cm1_in;
         s1_c0_ff    <= s1_c0_in;
         s1_unw_ff   <= s1_unw_in;
         s1_fresh_ff <= s1_fresh_in;
         byp_addr_ff <= byp_addr_in;
         byp_up_ff   <= byp_up_in;
         byp_lo_ff   <= byp_lo_in;
         s2_ctr_ff   <= s2_ctr_in;
         win_ff      <= win_in;
      end
   end

   assign s2_ctl     = s2_ctl_ff;
   assign window     = win_ff;
   assign s2_ctr_pix = s2_ctr_ff;

endmodule

### hw/rtl/rgbcf_kernel.sv
// Multiply-accumulate back end: 27 products, row sums, final sum with rounding and
// clamping, and the result register. Uses rgbcf_pkg.
module rgbcf_kernel
   import rgbcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  ctl_type               s2_ctl,
   input  window_type            window,
   input  pix_type               s2_ctr_pix,
   input  logic [COEF_ROW_W-1:0] coef_top_row,
   input  logic [COEF_ROW_W-1:0] coef_middle_row,
   input  logic [COEF_ROW_W-1:0] coef_bottom_row,
   output logic                  rsp_valid,
   output logic [CHAN_W-1:0]     out_red,
   output logic [CHAN_W-1:0]     out_green,
   output logic [CHAN_W-1:0]     out_blue,
   output logic                  frame_last
);

   // stage 3: products [channel][row][column]
   ctl_type                    s3_ctl_ff, s3_ctl_in;
   pix_type                    s3_ctr_ff, s3_ctr_in;
   logic signed [PROD_W-1:0]   prod_ff [NUM_CHAN][3][3];
   logic signed [PROD_W-1:0]   prod_in [NUM_CHAN][3][3];

   // stage 4: row sums [channel][row]
   ctl_type                    s4_ctl_ff, s4_ctl_in;
   pix_type                    s4_ctr_ff, s4_ctr_in;
   logic signed [ROWSUM_W-1:0] rsum_ff [NUM_CHAN][3];
   logic signed [ROWSUM_W-1:0] rsum_in [NUM_CHAN][3];

   // result register
   logic                       out_valid_ff, out_valid_in;
   pix_type                    out_pix_ff, out_pix_in;
   logic                       out_last_ff, out_last_in;

   logic [2:0][COEF_ROW_W-1:0] coef_rows;
   logic signed [SUM_W-1:0]    total;
   pix_type                    conv;

   assign coef_rows = {coef_bottom_row, coef_middle_row, coef_top_row};

   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_in[k][i][j] = $signed({1'b0, window[i][j][k*CHAN_W +: CHAN_W]}) *
                                  coef_at(coef_rows[i], j);
            end
         end
      end
      s3_ctl_in = s2_ctl;
      s3_ctr_in = s2_ctr_pix;
   end

   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         for (int i = 0; i < 3; i++) begin
            rsum_in[k][i] = ROWSUM_W'(prod_ff[k][i][0]) + ROWSUM_W'(prod_ff[k][i][1]) +
                            ROWSUM_W'(prod_ff[k][i][2]);
         end
      end
      s4_ctl_in = s3_ctl_ff;
      s4_ctr_in = s3_ctr_ff;
   end

   always_comb begin
      conv  = '0;
      total = '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
         total = SUM_W'(rsum_ff[k][0]) + SUM_W'(rsum_ff[k][1]) + SUM_W'(rsum_ff[k][2]);
         conv[k*CHAN_W +: CHAN_W] = round_clamp(total);
      end
      out_valid_in = s4_ctl_ff.valid && s4_ctl_ff.emit;
      out_pix_in   = s4_ctl_ff.interior ? conv : s4_ctr_ff;
      out_last_in  = s4_ctl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff    <= '0;
         s4_ctl_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_ctl_ff    <= s3_ctl_in;
         s4_ctl_ff    <= s4_ctl_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ctr_ff   <= s3_ctr_in;
         prod_ff     <= prod_in;
         s4_ctr_ff   <= s4_ctr_in;
         rsum_ff     <= rsum_in;
         out_pix_ff  <= out_pix_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign out_red    = out_pix_ff[0*CHAN_W +: CHAN_W];
   assign out_green  = out_pix_ff[1*CHAN_W +: CHAN_W];
   assign out_blue   = out_pix_ff[2*CHAN_W +: CHAN_W];
   assign frame_last = out_last_ff;

endmodule

### hw/rtl/rgb_3x3_convolution_filter.sv
// 3x3 RGB convolution filter, top level: configuration registers and pipeline glue.
// Path: the input item that completes a window passes stages 1 to 4 and then the result
// register; results trail inputs by image_width+1 items.
// Throughput: one pixel per clock; the whole pipeline holds while a result is stalled.
// Reset (synchronous): clears frame position, line store fill count, pipeline valids
// and loads default geometry and an identity kernel; no clearing pass over the stores.
module rgb_3x3_convolution_filter
   import rgbcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAN_W-1:0]     req_pix_red,
   input  logic [CHAN_W-1:0]     req_pix_green,
   input  logic [CHAN_W-1:0]     req_pix_blue,
   input  logic                  req_flush,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAN_W-1:0]     rsp_out_red,
   output logic [CHAN_W-1:0]     rsp_out_green,
   output logic [CHAN_W-1:0]     rsp_out_blue,
   output logic                  rsp_frame_last,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COEF_ROW_W-1:0] csr_data
);

   logic [WIDTH_REG_W-1:0]  image_width_ff, image_width_in;
   logic [HEIGHT_REG_W-1:0] image_height_ff, image_height_in;
   logic [COEF_ROW_W-1:0]   coef_top_ff, coef_top_in;
   logic [COEF_ROW_W-1:0]   coef_middle_ff, coef_middle_in;
   logic [COEF_ROW_W-1:0]   coef_bottom_ff, coef_bottom_in;

   logic       adv;
   ctl_type    s2_ctl;
   window_type window;
   pix_type    s2_ctr_pix;

   assign csr_ready = 1'b1;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      coef_top_in     = coef_top_ff;
      coef_middle_in  = coef_middle_ff;
      coef_bottom_in  = coef_bottom_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               image_width_in = csr_data[WIDTH_REG_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_data[HEIGHT_REG_W-1:0];
            end
            CSR_COEF_TOP: begin
               coef_top_in = csr_data;
            end
            CSR_COEF_MIDDLE: begin
               coef_middle_in = csr_data;
            end
            CSR_COEF_BOTTOM: begin
               coef_bottom_in = csr_data;
            end
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         coef_top_ff     <= COEF_EDGE_RESET;
         coef_middle_ff  <= COEF_MIDDLE_RESET;
         coef_bottom_ff  <= COEF_EDGE_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         coef_top_ff     <= coef_top_in;
         coef_middle_ff  <= coef_middle_in;
         coef_bottom_ff  <= coef_bottom_in;
      end
   end

   // advance everything unless a result is waiting on a stalled output
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   rgbcf_linebuf u_linebuf (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .req_valid    (req_valid),
      .pix_red      (req_pix_red),
      .pix_green    (req_pix_green),
      .pix_blue     (req_pix_blue),
      .flush        (req_flush),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .s2_ctl       (s2_ctl),
      .window       (window),
      .s2_ctr_pix   (s2_ctr_pix)
   );

   rgbcf_kernel u_kernel (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .s2_ctl          (s2_ctl),
      .window          (window),
      .s2_ctr_pix      (s2_ctr_pix),
      .coef_top_row    (coef_top_ff),
      .coef_middle_row (coef_middle_ff),
      .coef_bottom_row (coef_bottom_ff),
      .rsp_valid       (rsp_valid),
      .out_red         (rsp_out_red),
      .out_green       (rsp_out_green),
      .out_blue        (rsp_out_blue),
      .frame_last      (rsp_frame_last)
   );

endmodule

### hw/rtl/rgbcf_checker.sv
// Port-level checker for the 3x3 RGB convolution filter, bound to the top level.
// Uses the assertion macros of rgb_3x3_convolution_filter_macros.svh.
`include "rgb_3x3_convolution_filter_macros.svh"

module rgbcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_green,
   input logic [7:0] rsp_out_blue,
   input logic       rsp_frame_last
);

   logic        quiet;
   logic [3:0]  quiet_hist_ff, quiet_hist_in;
   logic        quiet_run;
   logic        rsp_blocked;
   logic [24:0] rsp_word;

   // no input offered and output free to move
   assign quiet         = !req_valid && !rsp_stall;
   assign quiet_hist_in = {quiet_hist_ff[2:0], quiet};
   // quiet now and at every edge held in the quiet history register
   assign quiet_run     = quiet && (&quiet_hist_ff);
   assign rsp_blocked   = rsp_valid && rsp_stall;
   assign rsp_word      = {rsp_frame_last, rsp_out_blue, rsp_out_green, rsp_out_red};

   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_hist_ff <= '0;
      end else begin
         quiet_hist_ff <= quiet_hist_in;
      end
   end

   `RGBCF_ASSERT_NXT(a_rsp_hold, rsp_blocked, rsp_valid && $stable(rsp_word), "held result changed")
   `RGBCF_ASSERT_IMP(a_stall_cause, req_stall, rsp_blocked, "input stall without a waiting result")
   `RGBCF_ASSERT_NXT(a_drain, quiet_run, !rsp_valid, "result appeared from an empty pipeline")

endmodule

bind rgb_3x3_convolution_filter rgbcf_checker u_rgbcf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_red    (rsp_out_red),
   .rsp_out_green  (rsp_out_green),
   .rsp_out_blue   (rsp_out_blue),
   .rsp_frame_last (rsp_frame_last)
);
